// ===== rtl/core/hmng_pkg.sv =====
package hmng_pkg;

    // Field and register widths
    localparam int COORD_W    = 10;
    localparam int H_W        = 16;
    localparam int CNT_W      = 11;
    localparam int INV_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NORM_W     = 16;

    // Datapath widths
    localparam int DIFF_W    = H_W + 2;
    localparam int PROD_W    = DIFF_W + INV_W + 1;
    localparam int SLOPE_W   = 31;
    localparam int SQ_W      = 2 * SLOPE_W;
    localparam int Q_W       = 64;
    localparam int Q_TOP     = 62;
    localparam int MAG_W     = 32;
    localparam int LEN_W     = 32;
    localparam int FRAC_BITS = 14;
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int REM_W     = MAG_W + FRAC_BITS + 1;

    // Pipeline shape
    localparam int FRONT_STAGES = 7;
    localparam int SQRT_STEPS   = Q_W / 2;
    localparam int DIV_STEPS    = QUOT_W;
    localparam int DIV_LAT      = DIV_STEPS + 1;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + DIV_LAT + 1;

    // Constants
    localparam logic [SLOPE_W-1:0] SLOPE_LIMIT  = '1;
    localparam logic [MAG_W-1:0]   SLOPE_ONE    = 32'd512;
    localparam logic [Q_W-1:0]     SLOPE_ONE_SQ = 64'd262144;
    localparam logic [QUOT_W-1:0]  UNIT_Q14     = 15'd16384;

    // Register reset values
    localparam logic [CNT_W-1:0] COLUMNS_RST = 11'd1024;
    localparam logic [CNT_W-1:0] ROWS_RST    = 11'd1024;
    localparam logic [INV_W-1:0] INV_X_RST   = 16'd256;
    localparam logic [INV_W-1:0] INV_Y_RST   = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_INV_X   = 2'd2,
        CFG_INV_Y   = 2'd3
    } t_cfg_reg;

endpackage

// ===== rtl/core/hmng_round_div.sv =====
// Rounded quotient (mag * 2^14 + len/2) / len, one quotient bit per stage.
module hmng_round_div (
    input  logic                              i_clk,
    input  logic [hmng_pkg::MAG_W-1:0]        i_mag,
    input  logic [hmng_pkg::LEN_W-1:0]        i_len,
    output logic [hmng_pkg::QUOT_W-1:0]       o_quot
);

    localparam int REM_W     = hmng_pkg::REM_W;
    localparam int LEN_W     = hmng_pkg::LEN_W;
    localparam int QUOT_W    = hmng_pkg::QUOT_W;
    localparam int DIV_STEPS = hmng_pkg::DIV_STEPS;
    localparam int FRAC_BITS = hmng_pkg::FRAC_BITS;

    logic [REM_W-1:0]  r_rem [0:DIV_STEPS-1];
    logic [LEN_W-1:0]  r_len [0:DIV_STEPS-1];
    logic [QUOT_W-1:0] r_quo [1:DIV_STEPS];

    // Form the dividend with the rounding half added in
    always_ff @(posedge i_clk) begin
        r_rem[0] <= REM_W'({i_mag, {FRAC_BITS{1'b0}}}) + REM_W'(i_len >> 1);
        r_len[0] <= i_len;
    end

    for (genvar t = 0; t < DIV_STEPS; t++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - t;
        logic [REM_W-1:0] w_div;
        logic             w_ge;

        assign w_div = REM_W'(r_len[t]) << SH;
        assign w_ge  = (r_rem[t] >= w_div);

        if (t < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[t+1] <= w_ge ? (r_rem[t] - w_div) : r_rem[t];
                r_len[t+1] <= r_len[t];
            end
        end

        if (t == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_quo[1] <= QUOT_W'(w_ge);
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_quo[t+1] <= {r_quo[t][QUOT_W-2:0], w_ge};
            end
        end
    end

    assign o_quot = r_quo[DIV_STEPS];

endmodule

// ===== rtl/core/heightmap_normal_generator_unit.sv =====
// Channel      Direction  Transaction marked by          Payload
// ------------ ---------  -----------------------------  ---------------------------------------
// grid point   in         start high, busy low           i_col, i_row, i_h_center, i_h_left,
//                                                        i_h_right, i_h_prev_row, i_h_next_row
// normal       out        o_valid high for one cycle     o_normal_x, o_normal_y, o_normal_z
// config       in         i_cfg_wr_en high               i_cfg_index, i_cfg_data
//
// One grid point is taken every cycle; each normal passes through seven front stages,
// 32 square-root stages and 16 divider stages, then the output register. The square root
// (one result bit per stage) sets the depth.
// Reset is synchronous and active low; busy is high only while reset is applied.
// The receiver cannot stall, so the pipeline never holds: every stage advances each cycle.
module heightmap_normal_generator_unit #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic        [hmng_pkg::COORD_W-1:0]   i_col,
    input  logic        [hmng_pkg::COORD_W-1:0]   i_row,
    input  logic signed [hmng_pkg::H_W-1:0]       i_h_center,
    input  logic signed [hmng_pkg::H_W-1:0]       i_h_left,
    input  logic signed [hmng_pkg::H_W-1:0]       i_h_right,
    input  logic signed [hmng_pkg::H_W-1:0]       i_h_prev_row,
    input  logic signed [hmng_pkg::H_W-1:0]       i_h_next_row,
    output logic                                  o_valid,
    output logic signed [hmng_pkg::NORM_W-1:0]    o_normal_x,
    output logic signed [hmng_pkg::NORM_W-1:0]    o_normal_y,
    output logic        [hmng_pkg::QUOT_W-1:0]    o_normal_z,
    input  logic                                  i_cfg_wr_en,
    input  logic        [hmng_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [hmng_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W      = hmng_pkg::CNT_W;
    localparam int INV_W      = hmng_pkg::INV_W;
    localparam int H_W        = hmng_pkg::H_W;
    localparam int DIFF_W     = hmng_pkg::DIFF_W;
    localparam int PROD_W     = hmng_pkg::PROD_W;
    localparam int SLOPE_W    = hmng_pkg::SLOPE_W;
    localparam int SQ_W       = hmng_pkg::SQ_W;
    localparam int Q_W        = hmng_pkg::Q_W;
    localparam int MAG_W      = hmng_pkg::MAG_W;
    localparam int LEN_W      = hmng_pkg::LEN_W;
    localparam int QUOT_W     = hmng_pkg::QUOT_W;
    localparam int NORM_W     = hmng_pkg::NORM_W;
    localparam int SQRT_STEPS = hmng_pkg::SQRT_STEPS;
    localparam int DIV_LAT    = hmng_pkg::DIV_LAT;
    localparam int LATENCY    = hmng_pkg::LATENCY;

    // Count compare widths: wide enough for the configured count and for the maximum
    localparam int COL_CNT_W = ($clog2(MAX_COLUMNS + 1) > CNT_W) ?
                               $clog2(MAX_COLUMNS + 1) : CNT_W;
    localparam int ROW_CNT_W = ($clog2(MAX_ROWS + 1) > CNT_W) ?
                               $clog2(MAX_ROWS + 1) : CNT_W;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [MAG_W-1:0] mz;
        logic             fx;   // slope positive: negate the component
        logic             fy;
    } t_carry;

    typedef struct packed {
        logic [Q_W-1:0] q;
        t_carry         c;
    } t_norm;

    // ------------------------------------------------------------------
    // Slope numerator: one-sided at the edges (doubled), central inside
    // ------------------------------------------------------------------
    function automatic logic signed [DIFF_W-1:0] axis_diff(
        input logic                  first,
        input logic                  last,
        input logic signed [H_W-1:0] h_lo,
        input logic signed [H_W-1:0] h_mid,
        input logic signed [H_W-1:0] h_hi
    );
        logic signed [H_W:0] fwd;
        logic signed [H_W:0] bwd;
        logic signed [H_W:0] cen;
        fwd = {h_hi[H_W-1], h_hi} - {h_mid[H_W-1], h_mid};
        bwd = {h_mid[H_W-1], h_mid} - {h_lo[H_W-1], h_lo};
        cen = {h_hi[H_W-1], h_hi} - {h_lo[H_W-1], h_lo};
        if (first) begin
            return {fwd, 1'b0};
        end else if (last) begin
            return {bwd, 1'b0};
        end else begin
            return {cen[H_W], cen};
        end
    endfunction

    // Magnitude of the scaled slope, clipped to the slope limit
    function automatic logic [SLOPE_W-1:0] sat_mag(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] a;
        a = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        if (a > PROD_W'(hmng_pkg::SLOPE_LIMIT)) begin
            return hmng_pkg::SLOPE_LIMIT;
        end else begin
            return a[SLOPE_W-1:0];
        end
    endfunction

    // One normalising step: shift the sum of squares up by 2s and the magnitudes by s
    // while the sum stays below 2^62
    function automatic t_norm norm_step(input t_norm a, input int unsigned s);
        t_norm b;
        b = a;
        if ((a.q >> (hmng_pkg::Q_TOP - 2 * s)) == '0) begin
            b.q    = a.q << (2 * s);
            b.c.mx = a.c.mx << s;
            b.c.my = a.c.my << s;
            b.c.mz = a.c.mz << s;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_columns;
    logic [CNT_W-1:0] r_rows;
    logic [INV_W-1:0] r_inv_x;
    logic [INV_W-1:0] r_inv_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= hmng_pkg::COLUMNS_RST;
            r_rows    <= hmng_pkg::ROWS_RST;
            r_inv_x   <= hmng_pkg::INV_X_RST;
            r_inv_y   <= hmng_pkg::INV_Y_RST;
        end else if (i_cfg_wr_en) begin
            case (hmng_pkg::t_cfg_reg'(i_cfg_index))
                hmng_pkg::CFG_COLUMNS: r_columns <= i_cfg_data[CNT_W-1:0];
                hmng_pkg::CFG_ROWS:    r_rows    <= i_cfg_data[CNT_W-1:0];
                hmng_pkg::CFG_INV_X:   r_inv_x   <= i_cfg_data[INV_W-1:0];
                hmng_pkg::CFG_INV_Y:   r_inv_y   <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and valid pipeline
    // ------------------------------------------------------------------
    logic               w_accept;
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;
    assign n_vld    = {r_vld[LATENCY-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[LATENCY-1];

    // ------------------------------------------------------------------
    // Stage 1: edge classification and slope numerators
    // ------------------------------------------------------------------
    logic [COL_CNT_W-1:0] w_col_cnt;
    logic [ROW_CNT_W-1:0] w_row_cnt;
    logic                 w_col_first;
    logic                 w_col_last;
    logic                 w_row_first;
    logic                 w_row_last;

    // Clamp counts above the maximum
    assign w_col_cnt = (COL_CNT_W'(r_columns) > COL_CNT_W'(MAX_COLUMNS)) ?
                       COL_CNT_W'(MAX_COLUMNS) : COL_CNT_W'(r_columns);
    assign w_row_cnt = (ROW_CNT_W'(r_rows) > ROW_CNT_W'(MAX_ROWS)) ?
                       ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(r_rows);

    // First position wins even for degenerate counts; at or beyond the end goes backward
    assign w_col_first = (i_col == '0);
    assign w_row_first = (i_row == '0);
    assign w_col_last  = (COL_CNT_W'(i_col) + COL_CNT_W'(1)) >= w_col_cnt;
    assign w_row_last  = (ROW_CNT_W'(i_row) + ROW_CNT_W'(1)) >= w_row_cnt;

    logic signed [DIFF_W-1:0] r_s1_dx;
    logic signed [DIFF_W-1:0] r_s1_dy;

    always_ff @(posedge i_clk) begin
        r_s1_dx <= axis_diff(w_col_first, w_col_last, i_h_left, i_h_center, i_h_right);
        r_s1_dy <= axis_diff(w_row_first, w_row_last, i_h_prev_row, i_h_center,
                             i_h_next_row);
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by the reciprocal spacing
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_s2_px;
    logic signed [PROD_W-1:0] r_s2_py;

    always_ff @(posedge i_clk) begin
        r_s2_px <= PROD_W'(r_s1_dx) * PROD_W'($signed({1'b0, r_inv_x}));
        r_s2_py <= PROD_W'(r_s1_dy) * PROD_W'($signed({1'b0, r_inv_y}));
    end

    // ------------------------------------------------------------------
    // Stage 3: saturate, split into magnitude and direction
    // ------------------------------------------------------------------
    logic [SLOPE_W-1:0] r_s3_ax;
    logic [SLOPE_W-1:0] r_s3_ay;
    logic               r_s3_fx;
    logic               r_s3_fy;

    always_ff @(posedge i_clk) begin
        r_s3_ax <= sat_mag(r_s2_px);
        r_s3_ay <= sat_mag(r_s2_py);
        r_s3_fx <= !r_s2_px[PROD_W-1] && (r_s2_px != '0);
        r_s3_fy <= !r_s2_py[PROD_W-1] && (r_s2_py != '0);
    end

    // ------------------------------------------------------------------
    // Stage 4: squares
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]    r_s4_sqx;
    logic [SQ_W-1:0]    r_s4_sqy;
    logic [SLOPE_W-1:0] r_s4_ax;
    logic [SLOPE_W-1:0] r_s4_ay;
    logic               r_s4_fx;
    logic               r_s4_fy;

    always_ff @(posedge i_clk) begin
        r_s4_sqx <= SQ_W'(r_s3_ax) * SQ_W'(r_s3_ax);
        r_s4_sqy <= SQ_W'(r_s3_ay) * SQ_W'(r_s3_ay);
        r_s4_ax  <= r_s3_ax;
        r_s4_ay  <= r_s3_ay;
        r_s4_fx  <= r_s3_fx;
        r_s4_fy  <= r_s3_fy;
    end

    // ------------------------------------------------------------------
    // Stage 5: squared length of (-a, -b, 512)
    // ------------------------------------------------------------------
    t_norm r_s5;

    always_ff @(posedge i_clk) begin
        r_s5.q    <= Q_W'(r_s4_sqx) + Q_W'(r_s4_sqy) + hmng_pkg::SLOPE_ONE_SQ;
        r_s5.c.mx <= MAG_W'(r_s4_ax);
        r_s5.c.my <= MAG_W'(r_s4_ay);
        r_s5.c.mz <= hmng_pkg::SLOPE_ONE;
        r_s5.c.fx <= r_s4_fx;
        r_s5.c.fy <= r_s4_fy;
    end

    // ------------------------------------------------------------------
    // Stages 6 and 7: normalise the sum into [2^60, 2^63) by powers of four
    // ------------------------------------------------------------------
    t_norm r_s6;
    t_norm n_s6;
    t_norm n_s7;

    always_comb begin
        n_s6 = norm_step(norm_step(r_s5, 16), 8);
        n_s7 = norm_step(norm_step(norm_step(r_s6, 4), 2), 1);
    end

    always_ff @(posedge i_clk) begin
        r_s6 <= n_s6;
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage
    // ------------------------------------------------------------------
    logic [Q_W-1:0] r_rt_rem [0:SQRT_STEPS-1];
    logic [Q_W-1:0] r_rt_res [1:SQRT_STEPS];
    t_carry         r_rt_car [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        r_rt_rem[0] <= n_s7.q;
        r_rt_car[0] <= n_s7.c;
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_rt
        localparam logic [Q_W-1:0] BIT = Q_W'(1) << (hmng_pkg::Q_TOP - 2 * j);
        logic [Q_W-1:0] w_res_in;
        logic [Q_W-1:0] w_try;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign w_res_in = '0;
        end else begin : g_next
            assign w_res_in = r_rt_res[j];
        end

        assign w_try = w_res_in + BIT;
        assign w_ge  = (r_rt_rem[j] >= w_try);

        always_ff @(posedge i_clk) begin
            r_rt_res[j+1] <= w_ge ? ((w_res_in >> 1) + BIT) : (w_res_in >> 1);
            r_rt_car[j+1] <= r_rt_car[j];
        end

        if (j < SQRT_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rt_rem[j+1] <= w_ge ? (r_rt_rem[j] - w_try) : r_rt_rem[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounded division of each scaled magnitude by the length
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]   w_len;
    logic [QUOT_W-1:0]  w_qx;
    logic [QUOT_W-1:0]  w_qy;
    logic [QUOT_W-1:0]  w_qz;
    logic [DIV_LAT-1:0] r_fx_dly;
    logic [DIV_LAT-1:0] r_fy_dly;

    assign w_len = r_rt_res[SQRT_STEPS][LEN_W-1:0];

    hmng_round_div u_div_x (
        .i_clk  (i_clk),
        .i_mag  (r_rt_car[SQRT_STEPS].mx),
        .i_len  (w_len),
        .o_quot (w_qx)
    );

    hmng_round_div u_div_y (
        .i_clk  (i_clk),
        .i_mag  (r_rt_car[SQRT_STEPS].my),
        .i_len  (w_len),
        .o_quot (w_qy)
    );

    hmng_round_div u_div_z (
        .i_clk  (i_clk),
        .i_mag  (r_rt_car[SQRT_STEPS].mz),
        .i_len  (w_len),
        .o_quot (w_qz)
    );

    // Carry the directions alongside the dividers
    always_ff @(posedge i_clk) begin
        r_fx_dly <= {r_fx_dly[DIV_LAT-2:0], r_rt_car[SQRT_STEPS].fx};
        r_fy_dly <= {r_fy_dly[DIV_LAT-2:0], r_rt_car[SQRT_STEPS].fy};
    end

    // ------------------------------------------------------------------
    // Output register: apply the sign, the normal points against the slope
    // ------------------------------------------------------------------
    logic [NORM_W-1:0] w_ux;
    logic [NORM_W-1:0] w_uy;
    logic [NORM_W-1:0] r_nx;
    logic [NORM_W-1:0] r_ny;
    logic [QUOT_W-1:0] r_nz;

    assign w_ux = NORM_W'(w_qx);
    assign w_uy = NORM_W'(w_qy);

    always_ff @(posedge i_clk) begin
        r_nx <= r_fx_dly[DIV_LAT-1] ? (NORM_W'(0) - w_ux) : w_ux;
        r_ny <= r_fy_dly[DIV_LAT-1] ? (NORM_W'(0) - w_uy) : w_uy;
        r_nz <= w_qz;
    end

    assign o_normal_x = r_nx;
    assign o_normal_y = r_ny;
    assign o_normal_z = r_nz;

endmodule

// ===== rtl/core/hmng_checker.sv =====
module hmng_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [hmng_pkg::H_W-1:0]    i_h_center,
    input logic signed [hmng_pkg::H_W-1:0]    i_h_left,
    input logic signed [hmng_pkg::H_W-1:0]    i_h_right,
    input logic signed [hmng_pkg::H_W-1:0]    i_h_prev_row,
    input logic signed [hmng_pkg::H_W-1:0]    i_h_next_row,
    input logic                               o_valid,
    input logic signed [hmng_pkg::NORM_W-1:0] o_normal_x,
    input logic signed [hmng_pkg::NORM_W-1:0] o_normal_y,
    input logic        [hmng_pkg::QUOT_W-1:0] o_normal_z
);

    localparam int LATENCY = hmng_pkg::LATENCY;
    localparam int AGE_W   = $clog2(LATENCY + 1);

    // Cycles since reset was released, held at the pipeline depth
    logic [AGE_W-1:0] r_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else if (r_age != AGE_W'(LATENCY)) begin
            r_age <= r_age + AGE_W'(1);
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_age == AGE_W'(LATENCY)) |-> (o_valid == $past(start && !busy, LATENCY)))
        else $error("result strobe does not follow its transaction by the pipeline depth");

    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_z <= hmng_pkg::UNIT_Q14))
        else $error("normal_z beyond unit length");

    a_xy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384 &&
                     o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384))
        else $error("normal_x or normal_y beyond unit length");

    a_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_age == AGE_W'(LATENCY)) &&
         $past(start && !busy && i_h_left == i_h_center && i_h_right == i_h_center &&
               i_h_prev_row == i_h_center && i_h_next_row == i_h_center, LATENCY))
        |-> (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == hmng_pkg::UNIT_Q14))
        else $error("flat grid point did not give the straight-up normal");

endmodule

bind heightmap_normal_generator_unit hmng_checker u_hmng_checker (.*);

// ===== sim/hmng_normal_checker.sv =====
`timescale 1ns / 100ps

module hmng_normal_checker #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_busy,
    input  logic        [hmng_pkg::COORD_W-1:0]    i_col,
    input  logic        [hmng_pkg::COORD_W-1:0]    i_row,
    input  logic signed [hmng_pkg::H_W-1:0]        i_h_center,
    input  logic signed [hmng_pkg::H_W-1:0]        i_h_left,
    input  logic signed [hmng_pkg::H_W-1:0]        i_h_right,
    input  logic signed [hmng_pkg::H_W-1:0]        i_h_prev_row,
    input  logic signed [hmng_pkg::H_W-1:0]        i_h_next_row,
    input  logic                                   i_valid,
    input  logic signed [hmng_pkg::NORM_W-1:0]     i_normal_x,
    input  logic signed [hmng_pkg::NORM_W-1:0]     i_normal_y,
    input  logic        [hmng_pkg::QUOT_W-1:0]     i_normal_z,
    input  logic                                   i_cfg_wr_en,
    input  logic        [hmng_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [hmng_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                     o_error_count,
    output int                                     o_pending
);
    import hmng_pkg::*;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic        [QUOT_W-1:0] z;
    } t_normal;

    t_normal          normal_q[$];
    logic [CNT_W-1:0] columns_sh;
    logic [CNT_W-1:0] rows_sh;
    logic [INV_W-1:0] inv_x_sh;
    logic [INV_W-1:0] inv_y_sh;
    int               errors = 0;

    // Slope along one axis in signed Q22.9, saturated to +-(2^31 - 1)
    function automatic longint axis_gradient(input logic [COORD_W-1:0] pos,
                                             input logic [CNT_W-1:0] count_in,
                                             input int max_count,
                                             input longint lo, input longint mid,
                                             input longint hi,
                                             input logic [INV_W-1:0] recip);
        longint cnt;
        longint p;
        longint rcp;
        longint d;
        longint s;
        cnt = longint'(count_in);
        p   = longint'(pos);
        rcp = longint'(recip);
        if (cnt > max_count)
            cnt = longint'(max_count);
        if (p == 0)
            d = 2 * (hi - mid);
        else if (p + 1 >= cnt)
            d = 2 * (mid - lo);
        else
            d = hi - lo;
        s = d * rcp;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483647)
            s = -64'sd2147483647;
        return s;
    endfunction

    // Floor of the square root, two bits of radicand per step
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] probe;
        rem   = v;
        res   = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= res + probe) begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] scaled_part(input logic [63:0] mag, input int k,
                                                input logic [63:0] len);
        return (64'd16384 * (mag << k) + (len >> 1)) / len;
    endfunction

    function automatic t_normal predict_normal(
        input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
        input logic signed [H_W-1:0] hc, input logic signed [H_W-1:0] hl,
        input logic signed [H_W-1:0] hr, input logic signed [H_W-1:0] hp,
        input logic signed [H_W-1:0] hn);
        longint      sx;
        longint      sy;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] q;
        logic [63:0] len;
        logic [63:0] m;
        int          k;
        t_normal     n;
        sx = axis_gradient(col, columns_sh, MAX_COLUMNS, longint'(hl), longint'(hc),
                           longint'(hr), inv_x_sh);
        sy = axis_gradient(row, rows_sh, MAX_ROWS, longint'(hp), longint'(hc),
                           longint'(hn), inv_y_sh);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        q  = ax * ax + ay * ay + 64'd262144;
        k  = 0;
        while (q < (64'd1 << 60)) begin
            q = q << 2;
            k++;
        end
        len = root_floor(q);
        // each component points against its slope
        m   = scaled_part(ax, k, len);
        n.x = (sx > 0) ? -m[NORM_W-1:0] : m[NORM_W-1:0];
        m   = scaled_part(ay, k, len);
        n.y = (sy > 0) ? -m[NORM_W-1:0] : m[NORM_W-1:0];
        m   = scaled_part(64'd512, k, len);
        n.z = m[QUOT_W-1:0];
        return n;
    endfunction

    always @(posedge i_clk) begin : watch
        t_normal want;
        if (!i_rst_n) begin
            columns_sh = COLUMNS_RST;
            rows_sh    = ROWS_RST;
            inv_x_sh   = INV_X_RST;
            inv_y_sh   = INV_Y_RST;
            normal_q.delete();
        end else begin
            if (i_valid) begin
                if (normal_q.size() == 0) begin
                    $display("%0t: unexpected normal (%0d, %0d, %0d), none outstanding",
                             $time, i_normal_x, i_normal_y, i_normal_z);
                    errors++;
                end else begin
                    want = normal_q.pop_front();
                    if (i_normal_x !== want.x) begin
                        $display("%0t: normal_x expected %0d actual %0d",
                                 $time, want.x, i_normal_x);
                        errors++;
                    end
                    if (i_normal_y !== want.y) begin
                        $display("%0t: normal_y expected %0d actual %0d",
                                 $time, want.y, i_normal_y);
                        errors++;
                    end
                    if (i_normal_z !== want.z) begin
                        $display("%0t: normal_z expected %0d actual %0d",
                                 $time, want.z, i_normal_z);
                        errors++;
                    end
                end
            end
            // queue the expected normal behind those still outstanding
            if (i_start && !i_busy)
                normal_q = {normal_q, predict_normal(i_col, i_row, i_h_center, i_h_left,
                                                     i_h_right, i_h_prev_row,
                                                     i_h_next_row)};
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_COLUMNS: columns_sh = i_cfg_data[CNT_W-1:0];
                    CFG_ROWS:    rows_sh    = i_cfg_data[CNT_W-1:0];
                    CFG_INV_X:   inv_x_sh   = i_cfg_data[INV_W-1:0];
                    CFG_INV_Y:   inv_y_sh   = i_cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending     <= normal_q.size();
        o_error_count <= errors;
    end

endmodule

// ===== sim/tb_heightmap_normal_generator_unit.sv =====
`timescale 1ns / 100ps

module tb_heightmap_normal_generator_unit;
    import hmng_pkg::*;

    // Far beyond the slowest correct run: ~820 points at 70 % idle plus pipeline drains
    localparam int CYCLE_LIMIT = 200000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [COORD_W-1:0]      i_col;
    logic [COORD_W-1:0]      i_row;
    logic signed [H_W-1:0]   i_h_center;
    logic signed [H_W-1:0]   i_h_left;
    logic signed [H_W-1:0]   i_h_right;
    logic signed [H_W-1:0]   i_h_prev_row;
    logic signed [H_W-1:0]   i_h_next_row;
    logic                    o_valid;
    logic signed [NORM_W-1:0] o_normal_x;
    logic signed [NORM_W-1:0] o_normal_y;
    logic [QUOT_W-1:0]       o_normal_z;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    int error_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;   // transactions still to go back to back

    heightmap_normal_generator_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_h_center   (i_h_center),
        .i_h_left     (i_h_left),
        .i_h_right    (i_h_right),
        .i_h_prev_row (i_h_prev_row),
        .i_h_next_row (i_h_next_row),
        .o_valid      (o_valid),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    hmng_normal_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_h_center    (i_h_center),
        .i_h_left      (i_h_left),
        .i_h_right     (i_h_right),
        .i_h_prev_row  (i_h_prev_row),
        .i_h_next_row  (i_h_next_row),
        .i_valid       (o_valid),
        .i_normal_x    (o_normal_x),
        .i_normal_y    (o_normal_y),
        .i_normal_z    (o_normal_z),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a lost normal or a stuck busy ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_heightmap_normal_generator_unit: errors");
            $finish;
        end
    end

    // One register write per clock; the caller lowers the enable afterwards
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CNT_W-1:0] cols, input logic [CNT_W-1:0] rows,
                               input logic [INV_W-1:0] inv_x, input logic [INV_W-1:0] inv_y);
        write_reg(CFG_COLUMNS, CFG_DATA_W'(cols));
        write_reg(CFG_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_INV_X, inv_x);
        write_reg(CFG_INV_Y, inv_y);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Drop start and hold until every outstanding normal has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Offer one grid point, idling first at the given rate unless inside a burst.
    // The pending count is registered in the checker, so drain samples it only after the
    // clock has updated that register.
    task automatic send_point(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input logic signed [H_W-1:0] hc,
                              input logic signed [H_W-1:0] hl,
                              input logic signed [H_W-1:0] hr,
                              input logic signed [H_W-1:0] hp,
                              input logic signed [H_W-1:0] hn,
                              input int idle_pct);
        while (burst_left == 0 && $urandom_range(0, 99) < idle_pct) begin
            // idle cycle: scramble the payload so only start marks a transaction
            start        <= 1'b0;
            i_col        <= COORD_W'($urandom);
            i_row        <= COORD_W'($urandom);
            i_h_center   <= H_W'($urandom);
            i_h_left     <= H_W'($urandom);
            i_h_right    <= H_W'($urandom);
            i_h_prev_row <= H_W'($urandom);
            i_h_next_row <= H_W'($urandom);
            @(posedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(8, 24);
        start        <= 1'b1;
        i_col        <= col;
        i_row        <= row;
        i_h_center   <= hc;
        i_h_left     <= hl;
        i_h_right    <= hr;
        i_h_prev_row <= hp;
        i_h_next_row <= hn;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic signed [H_W-1:0] extreme_height();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // A raster walk over the configured grid for half of each coordinate, terrain-like heights,
    // mixed with edge positions, out-of-range positions, extreme heights and raw noise
    task automatic run_random_phase(input int items, input int idle_pct,
                                    input logic [CNT_W-1:0] cols,
                                    input logic [CNT_W-1:0] rows);
        int                 span_c;
        int                 span_r;
        int                 scan_c;
        int                 scan_r;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic signed [H_W-1:0] hc, hl, hr, hp, hn;
        span_c = (cols > 1024) ? 1024 : ((cols < 2) ? 2 : cols);
        span_r = (rows > 1024) ? 1024 : ((rows < 2) ? 2 : rows);
        scan_c = 0;
        scan_r = 0;
        repeat (items) begin
            case ($urandom_range(0, 9))
                0:       col = '0;
                1:       col = COORD_W'(span_c - 1);
                2:       col = COORD_W'(span_c);
                3:       col = COORD_W'($urandom);
                4:       col = COORD_W'(1);
                default: col = COORD_W'(scan_c);
            endcase
            case ($urandom_range(0, 9))
                0:       row = '0;
                1:       row = COORD_W'(span_r - 1);
                2:       row = COORD_W'(span_r);
                3:       row = COORD_W'($urandom);
                4:       row = COORD_W'(1);
                default: row = COORD_W'(scan_r);
            endcase
            // advance the raster position
            scan_c++;
            if (scan_c >= span_c) begin
                scan_c = 0;
                scan_r = (scan_r + 1 >= span_r) ? 0 : scan_r + 1;
            end
            case ($urandom_range(0, 5))
                0: begin
                    hc = H_W'($urandom); hl = H_W'($urandom); hr = H_W'($urandom);
                    hp = H_W'($urandom); hn = H_W'($urandom);
                end
                1: begin
                    hc = extreme_height(); hl = extreme_height(); hr = extreme_height();
                    hp = extreme_height(); hn = extreme_height();
                end
                default: begin
                    // gentle terrain: neighbours within a small window of the centre
                    hc = H_W'($urandom);
                    hl = hc + H_W'($urandom_range(0, 128)) - 16'sd64;
                    hr = hc + H_W'($urandom_range(0, 128)) - 16'sd64;
                    hp = hc + H_W'($urandom_range(0, 128)) - 16'sd64;
                    hn = hc + H_W'($urandom_range(0, 128)) - 16'sd64;
                end
            endcase
            send_point(col, row, hc, hl, hr, hp, hn, idle_pct);
        end
    endtask

    initial begin
        int                 phase;
        int                 idle;
        logic [CNT_W-1:0]   cols;
        logic [CNT_W-1:0]   rows;
        logic [INV_W-1:0]   inv_x;
        logic [INV_W-1:0]   inv_y;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_col        <= '0;
        i_row        <= '0;
        i_h_center   <= '0;
        i_h_left     <= '0;
        i_h_right    <= '0;
        i_h_prev_row <= '0;
        i_h_next_row <= '0;
        i_cfg_wr_en  <= 1'b0;
        i_cfg_index  <= CFG_COLUMNS;
        i_cfg_data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy);

        // Directed points on the reset-value grid (1024 x 1024, unit spacing)
        load_config(11'd1024, 11'd1024, 16'd256, 16'd256);
        send_point(10'd5, 10'd5, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 0);
        // first column and row: forward difference, left and previous ignored
        send_point(10'd0, 10'd0, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 0);
        // last column and row: backward difference, right and next ignored
        send_point(10'd1023, 10'd1023, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                   16'sh8000, 0);
        // widest central difference on both axes
        send_point(10'd10, 10'd10, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 0);
        send_point(10'd1023, 10'd0, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                   16'sh5555, 0);
        send_point(10'd512, 10'd1023, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                   16'shAAAA, 0);
        send_point(10'd0, 10'd512, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000,
                   16'shFFFF, 0);
        send_point(10'd300, 10'd300, 16'sd1, 16'sd0, 16'sd2, 16'sd1, 16'sd1, 0);
        send_point(10'd300, 10'd301, 16'sd7, 16'sd7, 16'sd7, 16'sd20, 16'sd3, 0);
        send_point(10'd1, 10'd1022, 16'sd40, 16'sd10, 16'sd90, -16'sd5, 16'sd60, 0);
        send_point(10'd1022, 10'd1, -16'sd40, -16'sd10, -16'sd90, 16'sd5, -16'sd60, 0);
        // unused neighbours at their extremes must not move a flat point
        send_point(10'd0, 10'd1023, 16'sd12, 16'sh8000, 16'sd12, 16'sd12, 16'sh7FFF, 0);
        send_point(10'd700, 10'd200, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF,
                   16'shFFFF, 0);
        send_point(10'd1023, 10'd1023, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
        drain();

        // Small grid with steep x and shallow y spacing; positions past the end
        load_config(11'd5, 11'd3, 16'hFFFF, 16'h0001);
        send_point(10'd4, 10'd2, 16'sd100, -16'sd100, 16'sd9, 16'sd300, 16'sd9, 0);
        send_point(10'd9, 10'd700, -16'sd3, 16'sd4, 16'sd1, -16'sd8, 16'sd1, 0);
        send_point(10'd3, 10'd1, 16'sd0, -16'sd1, 16'sd1, -16'sd2, 16'sd2, 0);
        send_point(10'd0, 10'd2, 16'sd5, 16'sd0, 16'sd6, 16'sd0, 16'sd0, 0);
        send_point(10'd1023, 10'd1023, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sh8000,
                   16'sd0, 0);
        send_point(10'd2, 10'd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sh7FFF, 0);
        drain();

        // Random phases: extremes of every register first, then ordinary grids
        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin cols = 11'd1024; rows = 11'd1024; inv_x = 16'hFFFF; inv_y = 16'hFFFF; end
                1: begin cols = 11'd2;    rows = 11'd2;    inv_x = 16'd1;    inv_y = 16'd1;    end
                2: begin cols = 11'd0;    rows = 11'd1;    inv_x = 16'd0;    inv_y = 16'd0;    end
                3: begin
                    cols  = 11'd2047;
                    rows  = 11'd1025;
                    inv_x = 16'd256;
                    inv_y = INV_W'($urandom);
                end
                4: begin
                    cols  = 11'd1;
                    rows  = 11'd0;
                    inv_x = INV_W'($urandom);
                    inv_y = 16'd0;
                end
                9: begin
                    cols  = COLUMNS_RST;
                    rows  = ROWS_RST;
                    inv_x = INV_X_RST;
                    inv_y = INV_Y_RST;
                end
                default: begin
                    // mostly small grids so the edges come round often
                    cols  = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(2, 1024))
                                                        : CNT_W'($urandom_range(2, 16));
                    rows  = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(2, 1024))
                                                        : CNT_W'($urandom_range(2, 16));
                    inv_x = ($urandom_range(0, 1) == 0) ? INV_W'($urandom_range(1, 1024))
                                                        : INV_W'($urandom_range(1, 65535));
                    inv_y = ($urandom_range(0, 1) == 0) ? INV_W'($urandom_range(1, 1024))
                                                        : INV_W'($urandom_range(1, 65535));
                end
            endcase
            idle = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 70 : 27);
            load_config(cols, rows, inv_x, inv_y);
            run_random_phase(80, idle, cols, rows);
            drain();
        end

        // Let any stray normal surface before the verdict
        repeat (LATENCY + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_heightmap_normal_generator_unit: clean");
        else
            $display("tb_heightmap_normal_generator_unit: errors");
        $finish;
    end

endmodule
